// ===== rtl/tmp_pkg.sv =====
// Shared widths and constants of the triangular motion profile generator.
package tmp_pkg;

  localparam int AXES      = 3;
  localparam int COORD_W   = 24;
  localparam int TIME_W    = 32;
  localparam int ACC_W     = 20;
  localparam int LEN_W     = 25;
  localparam int DUR_W     = 24;
  localparam int HALF_W    = 23;
  localparam int LIM_W     = 46;
  localparam int FRAC_W    = 17;
  localparam int MUL_AW    = 48;
  localparam int MUL_BW    = 24;
  localparam int SQ_W      = 50;
  localparam int TDIV_NW   = 47;
  localparam int FDIV_NW   = 16;

  localparam logic [ACC_W-1:0]  ACCEL_RST = 20'd20000;
  localparam logic [MUL_BW-1:0] DUR_K     = 24'd4000000;
  localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'h10000;

endpackage

// ===== rtl/tmp_in_if.sv =====
// Request channel carrying tick and start items into the profile generator.
interface tmp_in_if;
  import tmp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [TIME_W-1:0]         now_ms;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] start_z;
  logic signed [COORD_W-1:0] dest_x;
  logic signed [COORD_W-1:0] dest_y;
  logic signed [COORD_W-1:0] dest_z;

  modport source (output valid, opcode, now_ms, start_x, start_y, start_z,
                  dest_x, dest_y, dest_z, input ready);
  modport sink   (input valid, opcode, now_ms, start_x, start_y, start_z,
                  dest_x, dest_y, dest_z, output ready);
endinterface

// ===== rtl/tmp_out_if.sv =====
// Result channel carrying the commanded position out of the profile generator.
interface tmp_out_if;
  import tmp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      moving;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;

  modport source (output valid, moving, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, moving, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== rtl/triangular_motion_profile.sv =====
// Top level of the triangular velocity profile generator for a 3-axis move.
//
// Requests arrive on in_chan (valid/ready). A start request latches the start
// and end points, works out the path length and a duration of 2*sqrt(d/a) ms,
// and is then evaluated like a tick at its own time. A tick request returns
// the commanded point on the piecewise quadratic profile, or the end point
// with moving low once the move is over. Every request gives one result on
// out_chan. cfg_we/cfg_wdata write the acceleration register.
// One request is worked on at a time. A tick during a move passes through
// one evaluation step, three serial multiplies (squaring, scaling by the
// acceleration, interpolation) with the fraction divide before the last, and
// one step to hand the result over. The divide is skipped when the fraction
// saturates, and the scaling as well when nothing has been travelled yet or
// the path is of zero length. A tick after the move ends goes from the
// evaluation step straight to the final step. A start adds two multiplies,
// two roots, the duration divide and one latch step.
// The result sits in an output register, so the next request is taken while
// it waits; if the receiver stalls for longer than the next request takes,
// the block holds in its final step until the register empties.
// Reset is synchronous and clears the move, the points and the times, and
// sets the acceleration to 20000 um/s^2. No clearing pass is needed.
module triangular_motion_profile (
  input  logic                clk,
  input  logic                rst_n,
  tmp_in_if.sink              in_chan,
  tmp_out_if.source           out_chan,
  input  logic                cfg_we,
  input  logic [tmp_pkg::ACC_W-1:0] cfg_wdata
);
  import tmp_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SQ    = 13'b0000000000010,
    S_RT1   = 13'b0000000000100,
    S_KM    = 13'b0000000001000,
    S_DV    = 13'b0000000010000,
    S_RT2   = 13'b0000000100000,
    S_LATCH = 13'b0000001000000,
    S_EVAL  = 13'b0000010000000,
    S_QSQ   = 13'b0000100000000,
    S_AQ    = 13'b0001000000000,
    S_FR    = 13'b0010000000000,
    S_LP    = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   go_r, go_nxt;
  logic   active_r, active_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0] accel_r, accel_nxt;
  logic [ACC_W-1:0] a_eff;

  logic [TIME_W-1:0]         now_r;
  logic signed [COORD_W-1:0] st_r   [AXES];
  logic signed [COORD_W-1:0] ds_r   [AXES];
  logic signed [COORD_W-1:0] from_r [AXES];
  logic signed [COORD_W-1:0] to_r   [AXES];
  logic [TIME_W-1:0]         begin_r;
  logic [TIME_W-1:0]         finish_r;
  logic [HALF_W-1:0]         half_r;
  logic [LEN_W-1:0]          len_r;
  logic [LIM_W-1:0]          lim_r;
  logic [LEN_W-1:0]          d_r;
  logic [48:0]               q_r;
  logic [FRAC_W-1:0]         f_r;
  logic                      pend_moving_r;
  logic signed [COORD_W-1:0] pend_pos_r [AXES];
  logic                      out_moving_r;
  logic signed [COORD_W-1:0] out_pos_r  [AXES];

  logic                      in_fire;
  logic [MUL_AW-1:0]         mul_a    [AXES];
  logic [MUL_BW-1:0]         mul_b    [AXES];
  logic [MUL_AW+MUL_BW-1:0]  mul_p    [AXES];
  logic [AXES-1:0]           mul_done;
  logic                      mul_go;
  logic                      mul_all_done;
  logic [SQ_W-1:0]           sq_sum;
  logic [SQ_W-1:0]           sqrt_v;
  logic [SQ_W/2-1:0]         sqrt_root;
  logic                      sqrt_done;
  logic [TDIV_NW-1:0]        tdiv_quo;
  logic                      tdiv_done;
  logic [FDIV_NW-1:0]        fdiv_quo;
  logic                      fdiv_done;

  logic [DUR_W-1:0]          dur;
  logic [TIME_W:0]           fin_sum;
  logic [TIME_W-1:0]         elapsed;
  logic [DUR_W-1:0]          e24;
  logic                      e_lt_h;
  logic [DUR_W:0]            mdiff;
  logic [DUR_W-1:0]          mabs;
  logic [DUR_W-1:0]          sq_op;
  logic [48:0]               q_calc;
  logic                      q_le0;
  logic                      aq_over;
  logic [COORD_W-1:0]        span_mag [AXES];
  logic                      span_neg [AXES];
  logic [COORD_W-1:0]        dd_mag   [AXES];
  logic signed [COORD_W-1:0] lerp_pos [AXES];

  assign in_fire = in_chan.valid & in_chan.ready;
  assign a_eff   = (accel_r == '0) ? ACC_W'(1) : accel_r;

  // Per-axis arithmetic: requested span for the length, latched span for lerp.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      logic [COORD_W:0] dd;
      logic [COORD_W:0] sp;
      logic [COORD_W:0] stp;
      logic [COORD_W:0] res;
      logic [40:0]      rnd;
      dd  = {ds_r[i][COORD_W-1], ds_r[i]} - {st_r[i][COORD_W-1], st_r[i]};
      dd_mag[i] = dd[COORD_W] ? COORD_W'(-dd) : dd[COORD_W-1:0];
      sp  = {to_r[i][COORD_W-1], to_r[i]} - {from_r[i][COORD_W-1], from_r[i]};
      span_neg[i] = sp[COORD_W];
      span_mag[i] = sp[COORD_W] ? COORD_W'(-sp) : sp[COORD_W-1:0];
      // Round half away from zero on the magnitude, then apply the sign.
      rnd = mul_p[i][40:0] + 41'h8000;
      stp = rnd[40:16];
      res = span_neg[i] ? {from_r[i][COORD_W-1], from_r[i]} - stp
                        : {from_r[i][COORD_W-1], from_r[i]} + stp;
      lerp_pos[i] = res[COORD_W-1:0];
    end
  end

  assign sq_sum = SQ_W'(mul_p[0][47:0]) + SQ_W'(mul_p[1][47:0]) + SQ_W'(mul_p[2][47:0]);
  assign sqrt_v = (state_r == S_RT1) ? sq_sum : SQ_W'(tdiv_quo);
  assign dur    = sqrt_root[DUR_W-1:0];
  assign fin_sum = {1'b0, now_r} + (TIME_W+1)'(dur);

  // While a move is active the elapsed time never exceeds the duration.
  assign elapsed = (now_r < begin_r) ? '0 : now_r - begin_r;
  assign e24     = elapsed[DUR_W-1:0];
  assign e_lt_h  = e24 < {1'b0, half_r};
  assign mdiff   = {1'b0, half_r, 1'b0} - {1'b0, e24};
  assign mabs    = mdiff[DUR_W] ? DUR_W'(-mdiff) : mdiff[DUR_W-1:0];
  assign sq_op   = e_lt_h ? e24 : mabs;
  // Past half time the travelled distance goes as 2h^2 - (2h - e)^2.
  assign q_calc  = e_lt_h ? {1'b0, mul_p[0][47:0]}
                          : {mul_p[1][47:0], 1'b0} - {1'b0, mul_p[0][47:0]};
  assign q_le0   = q_calc[48] | (q_calc == '0);
  assign aq_over = mul_p[0] >= (MUL_AW+MUL_BW)'(lim_r);

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      mul_a[i] = '0;
      mul_b[i] = '0;
    end
    unique case (state_r)
      S_SQ: begin
        for (int i = 0; i < AXES; i++) begin
          mul_a[i] = MUL_AW'(dd_mag[i]);
          mul_b[i] = dd_mag[i];
        end
      end
      S_KM: begin
        mul_a[0] = MUL_AW'(d_r);
        mul_b[0] = DUR_K;
      end
      S_QSQ: begin
        mul_a[0] = MUL_AW'(sq_op);
        mul_b[0] = sq_op;
        mul_a[1] = MUL_AW'(half_r);
        mul_b[1] = MUL_BW'(half_r);
      end
      S_AQ: begin
        mul_a[0] = q_r[MUL_AW-1:0];
        mul_b[0] = MUL_BW'(a_eff);
      end
      S_LP: begin
        for (int i = 0; i < AXES; i++) begin
          mul_a[i] = MUL_AW'(span_mag[i]);
          mul_b[i] = MUL_BW'(f_r);
        end
      end
      default: ;
    endcase
  end

  assign mul_go = go_r & ((state_r == S_SQ) || (state_r == S_KM) || (state_r == S_QSQ) ||
                          (state_r == S_AQ) || (state_r == S_LP));
  assign mul_all_done = &mul_done;

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    tmp_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
      .clk   (clk),
      .rst_n (rst_n),
      .start (mul_go),
      .a     (mul_a[g]),
      .b     (mul_b[g]),
      .done  (mul_done[g]),
      .p     (mul_p[g])
    );
  end

  tmp_sqrt #(.W(SQ_W)) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r & ((state_r == S_RT1) || (state_r == S_RT2))),
    .v     (sqrt_v),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  tmp_div #(.NW(TDIV_NW), .DW(ACC_W)) u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r & (state_r == S_DV)),
    .rem_init ('0),
    .num      (mul_p[0][TDIV_NW-1:0]),
    .den      (a_eff),
    .done     (tdiv_done),
    .quo      (tdiv_quo)
  );

  tmp_div #(.NW(FDIV_NW), .DW(LIM_W)) u_fdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r & (state_r == S_FR)),
    .rem_init (mul_p[0][LIM_W-1:0]),
    .num      ('0),
    .den      (lim_r),
    .done     (fdiv_done),
    .quo      (fdiv_quo)
  );

  always_comb begin
    state_nxt     = state_r;
    go_nxt        = 1'b0;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r & ~out_chan.ready;
    accel_nxt     = cfg_we ? cfg_wdata : accel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = in_chan.opcode ? S_SQ : S_EVAL;
          go_nxt    = in_chan.opcode;
        end
      end
      S_SQ: begin
        if (mul_all_done) begin
          state_nxt = S_RT1;
          go_nxt    = 1'b1;
        end
      end
      S_RT1: begin
        if (sqrt_done) begin
          state_nxt = S_KM;
          go_nxt    = 1'b1;
        end
      end
      S_KM: begin
        if (mul_all_done) begin
          state_nxt = S_DV;
          go_nxt    = 1'b1;
        end
      end
      S_DV: begin
        if (tdiv_done) begin
          state_nxt = S_RT2;
          go_nxt    = 1'b1;
        end
      end
      S_RT2: begin
        if (sqrt_done) begin
          state_nxt = S_LATCH;
        end
      end
      S_LATCH: begin
        active_nxt = (dur != '0);
        state_nxt  = S_EVAL;
      end
      S_EVAL: begin
        if (!active_r || (now_r > finish_r)) begin
          active_nxt = 1'b0;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_QSQ;
          go_nxt    = 1'b1;
        end
      end
      S_QSQ: begin
        if (mul_all_done) begin
          state_nxt = (q_le0 || (len_r == '0)) ? S_LP : S_AQ;
          go_nxt    = 1'b1;
        end
      end
      S_AQ: begin
        if (mul_all_done) begin
          state_nxt = aq_over ? S_LP : S_FR;
          go_nxt    = 1'b1;
        end
      end
      S_FR: begin
        if (fdiv_done) begin
          state_nxt = S_LP;
          go_nxt    = 1'b1;
        end
      end
      S_LP: begin
        if (mul_all_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      accel_r     <= ACCEL_RST;
      begin_r     <= '0;
      finish_r    <= '0;
      half_r      <= '0;
      len_r       <= '0;
      for (int i = 0; i < AXES; i++) begin
        from_r[i] <= '0;
        to_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      accel_r     <= accel_nxt;
      if (state_r == S_LATCH) begin
        begin_r <= now_r;
        // A zero duration leaves the previous move's geometry in place.
        if (dur != '0) begin
          finish_r <= fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];
          half_r   <= dur[DUR_W-1:1];
          len_r    <= d_r;
          for (int i = 0; i < AXES; i++) begin
            from_r[i] <= st_r[i];
            to_r[i]   <= ds_r[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      now_r    <= in_chan.now_ms;
      st_r[0]  <= in_chan.start_x;
      st_r[1]  <= in_chan.start_y;
      st_r[2]  <= in_chan.start_z;
      ds_r[0]  <= in_chan.dest_x;
      ds_r[1]  <= in_chan.dest_y;
      ds_r[2]  <= in_chan.dest_z;
    end
    if ((state_r == S_RT1) && sqrt_done) begin
      d_r <= sqrt_root;
    end
    if ((state_r == S_LATCH) && (dur != '0)) begin
      lim_r <= mul_p[0][LIM_W:1];
    end
    if ((state_r == S_QSQ) && mul_all_done) begin
      q_r <= q_calc;
      if (q_le0 || (len_r == '0)) begin
        f_r <= '0;
      end
    end
    if ((state_r == S_AQ) && mul_all_done && aq_over) begin
      f_r <= FRAC_ONE;
    end
    if ((state_r == S_FR) && fdiv_done) begin
      f_r <= FRAC_W'(fdiv_quo);
    end
    if ((state_r == S_EVAL) && (!active_r || (now_r > finish_r))) begin
      pend_moving_r <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        pend_pos_r[i] <= to_r[i];
      end
    end
    if ((state_r == S_LP) && mul_all_done) begin
      pend_moving_r <= 1'b1;
      for (int i = 0; i < AXES; i++) begin
        pend_pos_r[i] <= lerp_pos[i];
      end
    end
    if ((state_r == S_DONE) && (!out_valid_r || out_chan.ready)) begin
      out_moving_r <= pend_moving_r;
      for (int i = 0; i < AXES; i++) begin
        out_pos_r[i] <= pend_pos_r[i];
      end
    end
  end

  assign in_chan.ready   = (state_r == S_IDLE);
  assign out_chan.valid  = out_valid_r;
  assign out_chan.moving = out_moving_r;
  assign out_chan.pos_x  = out_pos_r[0];
  assign out_chan.pos_y  = out_pos_r[1];
  assign out_chan.pos_z  = out_pos_r[2];

`ifndef NO_ASSERTIONS
  a_lim_set: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && (state_r == S_QSQ)) |-> (lim_r != '0))
    else $error("active move with a zero distance limit");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    (go_r && (state_r == S_LP)) |-> (f_r <= FRAC_ONE))
    else $error("interpolation fraction above one");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the final step");

  a_lerp_only_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QSQ) |-> active_r)
    else $error("profile evaluated without an active move");
`endif
endmodule

// ===== rtl/tmp_mul.sv =====
// Serial shift-and-add multiplier, one multiplier bit per cycle.
module tmp_mul #(
  parameter int AW = 48,
  parameter int BW = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] p
);
  localparam int PW = AW + BW;
  localparam int CW = $clog2(BW + 1);

  logic [PW-1:0] a_sh_r;
  logic [BW-1:0] b_sh_r;
  logic [PW-1:0] acc_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(BW);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh_r <= PW'(a);
      b_sh_r <= b;
      acc_r  <= '0;
    end else if (busy_r) begin
      if (b_sh_r[0]) begin
        acc_r <= acc_r + a_sh_r;
      end
      a_sh_r <= {a_sh_r[PW-2:0], 1'b0};
      b_sh_r <= {1'b0, b_sh_r[BW-1:1]};
    end
  end

  assign done = done_r;
  assign p    = acc_r;
endmodule

// ===== rtl/tmp_div.sv =====
// Restoring divider, one quotient bit per cycle, with a preset partial remainder.
module tmp_div #(
  parameter int NW = 47,
  parameter int DW = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] rem_init,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  // The partial remainder stays below the divisor, so it always fits DW bits.
  assign trial = {rem_r, num_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      num_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
      num_r <= {num_r[NW-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = num_r;
endmodule

// ===== rtl/tmp_sqrt.sv =====
// Integer square root, one root bit per cycle from two radicand bits.
module tmp_sqrt #(
  parameter int W = 50
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [W-1:0]    v,
  output logic            done,
  output logic [W/2-1:0]  root
);
  localparam int HW = W / 2;
  localparam int RW = HW + 1;
  localparam int CW = $clog2(HW + 1);

  logic [W-1:0]    v_r;
  logic [RW-1:0]   rem_r;
  logic [HW-1:0]   root_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic [RW+1:0]   diff;
  logic            fits;

  assign rem_sh = {rem_r, v_r[W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign diff   = rem_sh - trial;
  assign fits   = rem_sh >= trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(HW);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= v;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[W-3:0], 2'b00};
      rem_r  <= fits ? diff[RW-1:0] : rem_sh[RW-1:0];
      root_r <= {root_r[HW-2:0], fits};
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
